// ===== hw/rtl/exchange_sort_by_key_top_assert.svh =====
// Assertion macros used by the sorter's sequencer.
`ifndef EXCHANGE_SORT_BY_KEY_TOP_ASSERT_SVH
`define EXCHANGE_SORT_BY_KEY_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ESBK_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ESBK_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/esbk_pkg.sv =====
`timescale 1ns / 1ps

package esbk_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   localparam logic [1:0] MODE_ASC  = 2'd0;
   localparam logic [1:0] MODE_DESC = 2'd1;

   typedef struct packed {
      logic signed [31:0] sort_key;
      logic [15:0]        record_tag;
      logic               last_item;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_key;
      logic [15:0]        out_tag;
      logic               last_out;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] key;
      logic [15:0]        tag;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } mem_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } mem_rd_type;

endpackage

// ===== hw/rtl/esbk_mem.sv =====
`timescale 1ns / 1ps

module esbk_mem
   import esbk_pkg::*;
(
   input  logic       clock,
   input  mem_wr_type wr,
   input  mem_rd_type rd,
   output entry_type  rd_data
);

   entry_type store_ff [MAX_ENTRIES];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_ff[wr.addr] <= wr.data;
      end
   end

   // The read register holds its value whenever no read is issued.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rdata_ff <= store_ff[rd.addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

// ===== hw/rtl/esbk_seq.sv =====
`timescale 1ns / 1ps

module esbk_seq
   import esbk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] sort_mode,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   output mem_wr_type mem_wr,
   output mem_rd_type mem_rd,
   input  entry_type  mem_rdata
);

`include "exchange_sort_by_key_top_assert.svh"

   localparam logic [2:0] S_LOAD     = 3'd0;
   localparam logic [2:0] S_FETCH    = 3'd1;
   localparam logic [2:0] S_FIRST    = 3'd2;
   localparam logic [2:0] S_SCAN     = 3'd3;
   localparam logic [2:0] S_WB       = 3'd4;
   localparam logic [2:0] S_EMIT_RD  = 3'd5;
   localparam logic [2:0] S_EMIT_OUT = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             drop_ff, drop_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   logic [CNT_W-1:0] k_ff, k_in;
   entry_type        cur_ff, cur_in;

   logic             full;
   logic [CNT_W-1:0] n_new;
   logic             swap;
   logic             final_out;

   assign full      = (cnt_ff == CNT_W'(MAX_ENTRIES));
   assign n_new     = full ? cnt_ff : cnt_ff + CNT_W'(1);
   assign final_out = ((k_ff + CNT_W'(1)) == cnt_ff);

   // The one shared comparator: held entry i against the entry just read.
   always_comb begin
      swap = 1'b0;
      if (sort_mode == MODE_ASC) begin
         swap = $signed(cur_ff.key) > $signed(mem_rdata.key);
      end else if (sort_mode == MODE_DESC) begin
         swap = $signed(cur_ff.key) < $signed(mem_rdata.key);
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      drop_in   = drop_ff;
      i_in      = i_ff;
      issue_in  = issue_ff;
      pend_in   = pend_ff;
      pidx_in   = pidx_ff;
      k_in      = k_ff;
      cur_in    = cur_ff;
      mem_wr    = '0;
      mem_rd    = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;

      unique case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!full) begin
                  mem_wr.en       = 1'b1;
                  mem_wr.addr     = cnt_ff[IDX_W-1:0];
                  mem_wr.data.key = req_data.sort_key;
                  mem_wr.data.tag = req_data.record_tag;
                  cnt_in          = cnt_ff + CNT_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_data.last_item) begin
                  if ((sort_mode == MODE_ASC || sort_mode == MODE_DESC) &&
                      n_new >= CNT_W'(2)) begin
                     i_in     = '0;
                     state_in = S_FETCH;
                  end else begin
                     k_in     = '0;
                     state_in = S_EMIT_RD;
                  end
               end
            end
         end
         S_FETCH: begin
            mem_rd.en   = 1'b1;
            mem_rd.addr = i_ff[IDX_W-1:0];
            issue_in    = i_ff + CNT_W'(1);
            state_in    = S_FIRST;
         end
         S_FIRST: begin
            cur_in      = mem_rdata;
            mem_rd.en   = 1'b1;
            mem_rd.addr = issue_ff[IDX_W-1:0];
            pidx_in     = issue_ff[IDX_W-1:0];
            issue_in    = issue_ff + CNT_W'(1);
            pend_in     = 1'b1;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            // Compare entry pidx against the held entry while reading the next one.
            if (pend_ff && swap) begin
               mem_wr.en   = 1'b1;
               mem_wr.addr = pidx_ff;
               mem_wr.data = cur_ff;
               cur_in      = mem_rdata;
            end
            if (issue_ff < cnt_ff) begin
               mem_rd.en   = 1'b1;
               mem_rd.addr = issue_ff[IDX_W-1:0];
               pidx_in     = issue_ff[IDX_W-1:0];
               issue_in    = issue_ff + CNT_W'(1);
               pend_in     = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_WB;
            end
         end
         S_WB: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = i_ff[IDX_W-1:0];
            mem_wr.data = cur_ff;
            i_in        = i_ff + CNT_W'(1);
            if ((i_ff + CNT_W'(2)) < cnt_ff) begin
               state_in = S_FETCH;
            end else begin
               k_in     = '0;
               state_in = S_EMIT_RD;
            end
         end
         S_EMIT_RD: begin
            mem_rd.en   = 1'b1;
            mem_rd.addr = k_ff[IDX_W-1:0];
            state_in    = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (final_out) begin
                  cnt_in   = '0;
                  drop_in  = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  k_in     = k_ff + CNT_W'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff   <= '0;
         drop_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         drop_ff  <= drop_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      issue_ff <= issue_in;
      pidx_ff  <= pidx_in;
      k_ff     <= k_in;
      cur_ff   <= cur_in;
   end

   assign rsp_data.out_key  = mem_rdata.key;
   assign rsp_data.out_tag  = mem_rdata.tag;
   assign rsp_data.last_out = final_out;
   assign rsp_data.overflow = drop_ff;

   `ESBK_ASSERT_NOW(a_no_load_while_emit, req_ready, !rsp_valid, "load and emit overlap")
   `ESBK_ASSERT_NOW(a_no_rw_collision, mem_wr.en && mem_rd.en, mem_wr.addr != mem_rd.addr, "same-address read and write")
   `ESBK_ASSERT_NEXT(a_last_returns_to_load, rsp_valid && rsp_ready && rsp_data.last_out, req_ready && cnt_ff == '0, "set did not close")
   `ESBK_ASSERT_NOW(a_count_in_range, 1'b1, cnt_ff <= CNT_W'(MAX_ENTRIES), "entry count beyond capacity")

endmodule

// ===== hw/rtl/exchange_sort_by_key_top.sv =====
// Loading takes one record transaction per cycle. The set is then sorted with the single
// comparator, one held entry at a time, and no new record is taken until its last result
// is accepted. Each result is read from the store and then held on the output until taken.
// Reset is synchronous and active high; it empties the store, clears the drop flag and sets
// the mode to ascending. Store contents are not cleared.
`timescale 1ns / 1ps

module exchange_sort_by_key_top
   import esbk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_wdata
);

   // The sort mode register. Ascending and descending use the comparator; the
   // other two codes emit the records in arrival order.
   logic [1:0] mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ASC;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   mem_wr_type mem_wr;
   mem_rd_type mem_rd;
   entry_type  mem_rdata;

   // The sequencer loads records, runs the exchange sort by holding entry i in a
   // register and streaming entries i+1 onward past it, then emits the set.
   esbk_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .sort_mode (mode_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .mem_wr    (mem_wr),
      .mem_rd    (mem_rd),
      .mem_rdata (mem_rdata)
   );

   // The record store, with one write port and one registered read port.
   esbk_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (mem_rdata)
   );

endmodule

// ===== tb/sort_result_checker.sv =====
`timescale 1ns / 1ps

module sort_result_checker
   import esbk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_wdata,
   output int         mismatch_count,
   output int         results_pending
);

   logic signed [31:0] held_key [MAX_ENTRIES];
   logic [15:0]        held_tag [MAX_ENTRIES];
   int                 held_count;
   logic               records_dropped;
   logic [1:0]         order_mode;
   rsp_type            sorted_q [$];

   initial begin
      mismatch_count = 0;
      results_pending = 0;
      held_count = 0;
      records_dropped = 1'b0;
      order_mode = MODE_ASC;
   end

   // Printing is capped so that a badly broken block cannot flood the log.
   task automatic report_mismatch(input string msg);
      if (mismatch_count < 50) begin
         $display("%0t ns: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   // Puts the held records in order with the same pairwise exchanges the block
   // makes, then queues one result per record.
   task automatic order_and_queue();
      int                 i;
      int                 j;
      logic signed [31:0] k;
      logic [15:0]        t;
      logic               swap;
      rsp_type            r;
      for (i = 0; i + 1 < held_count; i++) begin
         for (j = i + 1; j < held_count; j++) begin
            swap = (order_mode == MODE_ASC  && held_key[i] > held_key[j]) ||
                   (order_mode == MODE_DESC && held_key[j] > held_key[i]);
            if (swap) begin
               k = held_key[i];
               t = held_tag[i];
               held_key[i] = held_key[j];
               held_tag[i] = held_tag[j];
               held_key[j] = k;
               held_tag[j] = t;
            end
         end
      end
      for (i = 0; i < held_count; i++) begin
         r.out_key  = held_key[i];
         r.out_tag  = held_tag[i];
         r.last_out = (i == held_count - 1);
         r.overflow = records_dropped;
         sorted_q.push_back(r);
      end
      held_count = 0;
      records_dropped = 1'b0;
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (sorted_q.size() == 0) begin
         report_mismatch($sformatf("result with none pending: key %0d tag %h",
                                   got.out_key, got.out_tag));
         return;
      end
      want = sorted_q.pop_front();
      if (got.out_key !== want.out_key) begin
         report_mismatch($sformatf("out_key: expected %0d, got %0d",
                                   want.out_key, got.out_key));
      end
      if (got.out_tag !== want.out_tag) begin
         report_mismatch($sformatf("out_tag: expected %h, got %h",
                                   want.out_tag, got.out_tag));
      end
      if (got.last_out !== want.last_out) begin
         report_mismatch($sformatf("last_out: expected %b, got %b",
                                   want.last_out, got.last_out));
      end
      if (got.overflow !== want.overflow) begin
         report_mismatch($sformatf("overflow: expected %b, got %b",
                                   want.overflow, got.overflow));
      end
   endtask

   // A result accepted at an edge can never belong to a record accepted at
   // the same edge, so results are checked before the record is taken in.
   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         records_dropped = 1'b0;
         order_mode = MODE_ASC;
         sorted_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_data);
         end
         if (req_valid && req_ready) begin
            if (held_count < MAX_ENTRIES) begin
               held_key[held_count] = req_data.sort_key;
               held_tag[held_count] = req_data.record_tag;
               held_count++;
            end else begin
               records_dropped = 1'b1;
            end
            if (req_data.last_item) begin
               order_and_queue();
            end
         end
         if (csr_we) begin
            order_mode = csr_wdata;
         end
      end
      results_pending = sorted_q.size();
   end

endmodule

// ===== tb/exchange_sort_by_key_top_tb.sv =====
`timescale 1ns / 1ps

module exchange_sort_by_key_top_tb;
   import esbk_pkg::*;

   // The package names only the two ordering modes. Any other mode value keeps
   // the loaded order, and both remaining encodings are exercised.
   localparam logic [1:0] MODE_KEEP     = 2'd2;
   localparam logic [1:0] MODE_KEEP_ALT = 2'd3;

   // The receiver stall used to back the block up. It is long enough to cover
   // the output of a whole set, so the records that follow pile up at the input.
   localparam int PRESSURE_HOLD = 300;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid;
   logic       req_ready;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_data;
   logic       csr_we;
   logic [1:0] csr_wdata;

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic pressure_arm = 1'b0;
   logic pressure_done;
   int   mismatch_count;
   int   results_pending;

   // The directed set covers the key extremes, both signs, a pair of equal keys
   // and tags with all bits low, all bits high and alternating bits.
   logic signed [31:0] extreme_keys [8] = '{
      32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1,
      32'sd1, 32'sd5, 32'sd5, -32'sd2147483647
   };
   logic [15:0] extreme_tags [8] = '{
      16'h0000, 16'hFFFF, 16'h1234, 16'h8000,
      16'h0001, 16'hAAAA, 16'h5555, 16'h00FF
   };

   exchange_sort_by_key_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // The checker watches both channels and the mode register, predicts every
   // sorted set and compares each result transaction as it is accepted.
   sort_result_checker results_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The run can never take this long: even with every record in a full set and the
   // slowest receiver, the run stays far below this bound.
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // The receiver drives ready at the falling edge. It normally idles at the
   // current rate. The first time a result shows up while pressure is armed,
   // it holds ready low for the PRESSURE_HOLD stall. Meanwhile the sender keeps
   // offering the next set, so the block has to stall its input.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      pressure_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && pressure_arm && !pressure_done && rsp_valid) begin
            hold_left = PRESSURE_HOLD;
            pressure_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Keys lean toward the extremes and a narrow band around zero. Equal keys
   // and sign changes therefore turn up often, while full random words still
   // toggle every bit.
   function automatic logic signed [31:0] pick_key();
      case ($urandom_range(5))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return int'($urandom_range(6)) - 3;
         default: return $urandom();
      endcase
   endfunction

   // Each call starts at a falling edge and returns at a falling edge. Valid is
   // left high after the transaction, and the next call either lowers it for an
   // idle gap or puts new data on it directly.
   task automatic send_record(input logic signed [31:0] key, input logic [15:0] tag,
                              input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.sort_key   = key;
      req_data.record_tag = tag;
      req_data.last_item  = last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_random_set(input int count);
      for (int k = 0; k < count; k++) begin
         send_record(pick_key(), 16'($urandom_range(65535)), k == count - 1);
      end
   endtask

   // Most sets are short, which keeps sorting fast. Now and then a set runs up
   // to the store size or past it, and the overflow path then gets hit.
   task automatic send_random_sets(input int budget);
      int count;
      while (budget > 0) begin
         if ($urandom_range(12) == 0) begin
            count = $urandom_range(58, 70);
         end else begin
            count = $urandom_range(1, 10);
         end
         send_random_set(count);
         budget -= count;
      end
   endtask

   task automatic send_extreme_set();
      for (int k = 0; k < 8; k++) begin
         send_record(extreme_keys[k], extreme_tags[k], k == 7);
      end
   endtask

   // Every phase ends on a record marked last. Once its final result is in,
   // the store is empty and the block is idle. The short pause that follows
   // covers the block's return to loading.
   task automatic drain();
      req_valid = 1'b0;
      while (results_pending != 0) begin
         @(negedge clock);
      end
      repeat (12) @(negedge clock);
   endtask

   // A mode write takes a single cycle and is issued only when the block is idle.
   task automatic write_mode(input logic [1:0] mode);
      csr_we = 1'b1;
      csr_wdata = mode;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      send_idle_pct = 26;
      recv_idle_pct = 51;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed part: the extreme set in both orders, a set of one record, and
      // short sets under both order-keeping mode encodings.
      write_mode(MODE_ASC);
      send_extreme_set();
      send_record(32'sd42, 16'h7FFF, 1'b1);
      drain();
      write_mode(MODE_DESC);
      send_extreme_set();
      drain();
      write_mode(MODE_KEEP);
      send_random_set(4);
      drain();
      write_mode(MODE_KEEP_ALT);
      send_random_set(3);
      drain();

      // Random part, first idling pattern: ascending order.
      write_mode(MODE_ASC);
      send_random_sets(40);
      drain();

      // Second idling pattern, descending order. The first set overflows the
      // store. Its last record is one of the dropped ones, and it must still
      // close the set.
      send_idle_pct = 51;
      recv_idle_pct = 26;
      write_mode(MODE_DESC);
      send_random_set(70);
      send_random_sets(20);
      drain();

      // No idling from here on. Both order-keeping encodings are used again.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_mode(MODE_KEEP);
      send_random_sets(15);
      drain();
      write_mode(MODE_KEEP_ALT);
      send_random_sets(15);
      drain();

      // Back pressure: the receiver stalls on the first set's output, and the
      // second set waits at the input. The set of exactly 64 fills the store
      // without dropping any record.
      write_mode(MODE_ASC);
      pressure_arm = 1'b1;
      send_random_set(20);
      send_random_set(20);
      send_random_set(64);
      drain();
      write_mode(MODE_DESC);
      send_random_sets(15);
      drain();

      if (mismatch_count == 0 && results_pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
